[rtl/roisac_pkg.sv]
package roisac_pkg;

	// edge scaling precision
	localparam int RATIO_FRAC_BITS = 8;

	// field widths
	localparam int IN_W    = 14;
	localparam int OUT_W   = 17;
	localparam int RATIO_W = 10;
	localparam int LIM_W   = 13;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 3;

	localparam int IN_TDATA_W  = ((4 * IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((4 * OUT_W + STAT_W + 7) / 8) * 8;

	// internal arithmetic widths
	localparam int SPAN_W = IN_W + 1;
	localparam int PROD_W = SPAN_W + RATIO_W + 1;
	localparam int MID_W  = SPAN_W + RATIO_FRAC_BITS;
	localparam int SUM_W  = ((PROD_W > MID_W) ? PROD_W : MID_W) + 1;
	localparam int EDGE_W = SUM_W - RATIO_FRAC_BITS - 1;
	localparam int WORK_W = EDGE_W + 2;

	// register reset values
	localparam logic [RATIO_W-1:0] SCALE_RATIO_RST    = RATIO_W'(256);
	localparam logic [LIM_W-1:0]   FRAME_WIDTH_RST    = LIM_W'(1920);
	localparam logic [LIM_W-1:0]   FRAME_HEIGHT_RST   = LIM_W'(1080);
	localparam logic [LIM_W-1:0]   MIN_BOX_WIDTH_RST  = LIM_W'(16);
	localparam logic [LIM_W-1:0]   MAX_BOX_WIDTH_RST  = LIM_W'(784);
	localparam logic [LIM_W-1:0]   MIN_BOX_HEIGHT_RST = LIM_W'(16);
	localparam logic [LIM_W-1:0]   MAX_BOX_HEIGHT_RST = LIM_W'(784);

	typedef enum logic [IDX_W-1:0] {
		REG_SCALE_RATIO    = 3'd0,
		REG_FRAME_WIDTH    = 3'd1,
		REG_FRAME_HEIGHT   = 3'd2,
		REG_MIN_BOX_WIDTH  = 3'd3,
		REG_MAX_BOX_WIDTH  = 3'd4,
		REG_MIN_BOX_HEIGHT = 3'd5,
		REG_MAX_BOX_HEIGHT = 3'd6
	} reg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_TOO_LARGE = 2'd1,
		STAT_TOO_SMALL = 2'd2,
		STAT_OUTSIDE   = 2'd3
	} status_t;

endpackage

[rtl/roisac_span.sv]
module roisac_span (
	input  logic signed [roisac_pkg::IN_W-1:0]    lo,
	input  logic signed [roisac_pkg::IN_W-1:0]    hi,
	input  logic        [roisac_pkg::RATIO_W-1:0] ratio,
	output logic signed [roisac_pkg::EDGE_W-1:0]  new_lo,
	output logic signed [roisac_pkg::EDGE_W-1:0]  new_hi
);
	import roisac_pkg::*;

	logic signed [SPAN_W-1:0] span_sum;
	logic signed [SPAN_W-1:0] span_dif;
	logic signed [PROD_W-1:0] half;
	logic signed [SUM_W-1:0]  mid;
	logic signed [SUM_W-1:0]  lo_fix;
	logic signed [SUM_W-1:0]  hi_fix;

	// center and half extent in 2^-(frac+1) pixel units
	assign span_sum = SPAN_W'(lo) + SPAN_W'(hi);
	assign span_dif = SPAN_W'(hi) - SPAN_W'(lo);
	assign half     = PROD_W'(span_dif) * $signed(PROD_W'({1'b0, ratio}));
	assign mid      = SUM_W'(span_sum) <<< RATIO_FRAC_BITS;
	assign lo_fix   = mid - SUM_W'(half);
	assign hi_fix   = mid + SUM_W'(half);

	// truncate toward zero: floor shift, plus one for negative inexact values
	function automatic logic signed [EDGE_W-1:0] trunc_edge(input logic signed [SUM_W-1:0] v);
		logic signed [EDGE_W-1:0] q;
		q = $signed(v[SUM_W-1:RATIO_FRAC_BITS+1]);
		if (v[SUM_W-1] && (v[RATIO_FRAC_BITS:0] != '0))
			q = q + EDGE_W'(1);
		return q;
	endfunction

	assign new_lo = trunc_edge(lo_fix);
	assign new_hi = trunc_edge(hi_fix);

endmodule

[rtl/roi_scale_align_check.sv]
// Box rescale and check: each box transfer on s_* gives exactly one result on m_*.
// The box is scaled about its center by scale_ratio, aligned (left/top even,
// right/bottom odd when non-negative), right/bottom clamped to the frame, then
// checked for size and placement. The block takes a box every cycle while
// s_tready is high. A box passes from the input register to the result register,
// and m_tvalid rises when the result register loads. While m_tready is low the
// result register holds, and the input register also holds once it is full, so
// at most two boxes wait inside. Configuration must be written on cfg_* while no
// box is in flight; the block itself does not enforce this. cfg_ready is always
// high.
module roi_scale_align_check (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// box in
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [13:0] box_left, [27:14] box_top, [41:28] box_right, [55:42] box_bottom
	input  logic [roisac_pkg::IN_TDATA_W-1:0]     s_tdata,
	// result out
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [16:0] new_left, [33:17] new_top, [50:34] new_right, [67:51] new_bottom,
	// [69:68] status, [71:70] zero
	output logic [roisac_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [roisac_pkg::IDX_W-1:0]          cfg_index,
	input  logic [roisac_pkg::LIM_W-1:0]          cfg_data
);
	import roisac_pkg::*;

	logic [RATIO_W-1:0] scale_ratio_q;
	logic [LIM_W-1:0]   frame_width_q;
	logic [LIM_W-1:0]   frame_height_q;
	logic [LIM_W-1:0]   min_box_width_q;
	logic [LIM_W-1:0]   max_box_width_q;
	logic [LIM_W-1:0]   min_box_height_q;
	logic [LIM_W-1:0]   max_box_height_q;

	logic                    valid_s1;
	logic signed [IN_W-1:0]  left_s1;
	logic signed [IN_W-1:0]  top_s1;
	logic signed [IN_W-1:0]  right_s1;
	logic signed [IN_W-1:0]  bottom_s1;

	logic                    valid_s2;
	logic [OUT_W-1:0]        left_s2;
	logic [OUT_W-1:0]        top_s2;
	logic [OUT_W-1:0]        right_s2;
	logic [OUT_W-1:0]        bottom_s2;
	status_t                 status_s2;

	logic adv;

	// configuration register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_ratio_q    <= SCALE_RATIO_RST;
			frame_width_q    <= FRAME_WIDTH_RST;
			frame_height_q   <= FRAME_HEIGHT_RST;
			min_box_width_q  <= MIN_BOX_WIDTH_RST;
			max_box_width_q  <= MAX_BOX_WIDTH_RST;
			min_box_height_q <= MIN_BOX_HEIGHT_RST;
			max_box_height_q <= MAX_BOX_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCALE_RATIO:    scale_ratio_q    <= cfg_data[RATIO_W-1:0];
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data;
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data;
				REG_MIN_BOX_WIDTH:  min_box_width_q  <= cfg_data;
				REG_MAX_BOX_WIDTH:  max_box_width_q  <= cfg_data;
				REG_MIN_BOX_HEIGHT: min_box_height_q <= cfg_data;
				REG_MAX_BOX_HEIGHT: max_box_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			left_s1   <= $signed(s_tdata[IN_W-1:0]);
			top_s1    <= $signed(s_tdata[2*IN_W-1:IN_W]);
			right_s1  <= $signed(s_tdata[3*IN_W-1:2*IN_W]);
			bottom_s1 <= $signed(s_tdata[4*IN_W-1:3*IN_W]);
		end
	end

	// left and top raised to zero
	logic signed [IN_W-1:0] left_c;
	logic signed [IN_W-1:0] top_c;

	assign left_c = left_s1[IN_W-1] ? '0 : left_s1;
	assign top_c  = top_s1[IN_W-1]  ? '0 : top_s1;

	logic signed [EDGE_W-1:0] nl_raw, nr_raw, nt_raw, nb_raw;

	roisac_span u_span_x (
		.lo     (left_c),
		.hi     (right_s1),
		.ratio  (scale_ratio_q),
		.new_lo (nl_raw),
		.new_hi (nr_raw)
	);

	roisac_span u_span_y (
		.lo     (top_c),
		.hi     (bottom_s1),
		.ratio  (scale_ratio_q),
		.new_lo (nt_raw),
		.new_hi (nb_raw)
	);

	// clamp to frame and align
	logic signed [WORK_W-1:0] fw_s, fh_s;
	logic signed [WORK_W-1:0] nr_clip, nb_clip;
	logic signed [WORK_W-1:0] nl, nt, nr, nb;

	assign fw_s    = $signed(WORK_W'(frame_width_q));
	assign fh_s    = $signed(WORK_W'(frame_height_q));
	assign nr_clip = (WORK_W'(nr_raw) > fw_s) ? fw_s : WORK_W'(nr_raw);
	assign nb_clip = (WORK_W'(nb_raw) > fh_s) ? fh_s : WORK_W'(nb_raw);

	assign nl = WORK_W'(nl_raw) + WORK_W'(nl_raw[0]);
	assign nt = WORK_W'(nt_raw) + WORK_W'(nt_raw[0]);
	assign nr = (nr_clip[0] && !nr_clip[WORK_W-1]) ? nr_clip : nr_clip - WORK_W'(1);
	assign nb = (nb_clip[0] && !nb_clip[WORK_W-1]) ? nb_clip : nb_clip - WORK_W'(1);

	// size and placement checks; a negative extent counts as huge
	logic signed [WORK_W:0] w_dif, h_dif;
	logic w_big, h_big, w_small, h_small, edge_ok;
	status_t status_c;

	assign w_dif   = (WORK_W+1)'(nr) - (WORK_W+1)'(nl);
	assign h_dif   = (WORK_W+1)'(nb) - (WORK_W+1)'(nt);
	assign w_big   = w_dif[WORK_W] || (w_dif > $signed((WORK_W+1)'(max_box_width_q)));
	assign h_big   = h_dif[WORK_W] || (h_dif > $signed((WORK_W+1)'(max_box_height_q)));
	assign w_small = !w_dif[WORK_W] && (w_dif < $signed((WORK_W+1)'(min_box_width_q)));
	assign h_small = !h_dif[WORK_W] && (h_dif < $signed((WORK_W+1)'(min_box_height_q)));
	assign edge_ok = !nl[WORK_W-1] && !nt[WORK_W-1] && (nr <= fw_s) && (nb <= fh_s);

	always_comb begin
		if (w_big || h_big)
			status_c = STAT_TOO_LARGE;
		else if (w_small || h_small)
			status_c = STAT_TOO_SMALL;
		else if (!edge_ok)
			status_c = STAT_OUTSIDE;
		else
			status_c = STAT_OK;
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			left_s2   <= nl[OUT_W-1:0];
			top_s2    <= nt[OUT_W-1:0];
			right_s2  <= nr[OUT_W-1:0];
			bottom_s2 <= nb[OUT_W-1:0];
			status_s2 <= status_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_TDATA_W'({status_s2, bottom_s2, right_s2, top_s2, left_s2});

endmodule
